[rtl/psm_pkg.sv]
// psm_pkg: shared types and constants for the pcm sfx/music mixer
// depends on nothing; used by all rtl files of the mixer
package psm_pkg;

	localparam int NUM_CH   = 4;
	localparam int POS_W    = 16;
	localparam int SAMP_W   = 8;
	localparam int VOL_W    = 8;
	localparam int CH_W     = 2;
	localparam int ACT_W    = 3;
	localparam int IN_W     = 72;
	localparam int OUT_W    = 80;

	localparam logic [ACT_W-1:0] ACT_TICK       = 3'd0;
	localparam logic [ACT_W-1:0] ACT_START_FX   = 3'd1;
	localparam logic [ACT_W-1:0] ACT_STOP_FX    = 3'd2;
	localparam logic [ACT_W-1:0] ACT_START_MUS  = 3'd3;
	localparam logic [ACT_W-1:0] ACT_STOP_MUS   = 3'd4;

	localparam logic [VOL_W-1:0] VOL_RESET  = 8'd128;
	localparam logic [VOL_W-1:0] CH_VOL_RST = 8'd255;
	localparam logic [SAMP_W-1:0] SILENCE   = 8'd128;

	// classified item passed from front to back, action in the lowest bits
	typedef struct packed {
		logic [CH_W-1:0]              target_channel;
		logic                         effect_repeat;
		logic [POS_W-1:0]             effect_length;
		logic [NUM_CH-1:0][SAMP_W-1:0] samples;
		logic [SAMP_W-1:0]            music_pcm;
		logic                         music_valid;
		logic [ACT_W-1:0]             action;
	} item_t;

	// result item fields
	typedef struct packed {
		logic [NUM_CH-1:0][POS_W-1:0] next_pos;
		logic                         music_on;
		logic [NUM_CH-1:0]            active_mask;
		logic [CH_W-1:0]              start_channel;
		logic                         start_ok;
		logic [SAMP_W-1:0]            mixed_sample;
	} result_t;

endpackage

[rtl/pcm_sfx_music_mixer_core.sv]
// pcm_sfx_music_mixer_core: top level of the pcm sfx/music mixer
// depends on psm_pkg, psm_front, psm_back
//
// usage:
//   s_axis carries one item per action (tick, start/stop effect, start/stop music)
//   m_axis returns exactly one result item per accepted item, in order
//   cfg_we/cfg_wdata write the effect volume latched by later effect starts
// path: an accepted item waits in the queue, then the engine registers its result in the
//   output reg, from which m_axis hands it on
// throughput: one item per cycle unless stalled; the engine retires one item each cycle
//   since the channel update and the four 8x8 multiplies fit a single stage
// reset: all channels inactive, lengths and positions zero, channel volumes 255,
//   music off, effect volume 128, queue and output empty
// stall: when a result waits and m_tready is low the output register holds, the engine stops,
//   and the two-entry queue fills before s_tready drops
module pcm_sfx_music_mixer_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	// action, music_valid, music pcm, sample_ch0..3, effect_length,
	// effect_repeat, target_channel (from bit 0 up), zero pad
	input  logic [71:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// mixed_sample, start_ok, start_channel, active_mask, music_on,
	// next_pos0..3 (from bit 0 up)
	output logic [79:0] m_tdata
);
	import psm_pkg::*;

	item_t   q_item;
	result_t res;
	logic    q_valid, q_ready;

	psm_front u_front (
		.clk, .arst_n, .s_tvalid, .s_tready, .s_tdata,
		.q_valid, .q_ready, .q_item
	);

	psm_back u_back (
		.clk, .arst_n, .cfg_we, .cfg_wdata,
		.q_valid, .q_ready, .q_item,
		.m_tvalid, .m_tready, .m_res(res)
	);

	assign m_tdata = res;

	// result held while stalled
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata)) else $error("result changed under stall");
	// start_ok only ever reports a channel that is now active
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && res.start_ok |-> res.active_mask[res.start_channel])
		else $error("started channel not active");
	// non-start results report no channel
	a_nostart: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !res.start_ok |-> res.start_channel == '0)
		else $error("channel reported without start");

endmodule

[rtl/psm_front.sv]
// psm_front: input unpacking and two-entry queue toward the mixer engine
// depends on psm_pkg
module psm_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [psm_pkg::IN_W-1:0] s_tdata,
	output logic                  q_valid,
	input  logic                  q_ready,
	output psm_pkg::item_t        q_item
);
	import psm_pkg::*;

	item_t     in_item;
	item_t     buf_q [2];
	logic      wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;
	logic      push, pop;

	// unpack the stream word
	always_comb begin
		in_item.action         = s_tdata[2:0];
		in_item.music_valid    = s_tdata[3];
		in_item.music_pcm      = s_tdata[11:4];
		in_item.samples[0]     = s_tdata[19:12];
		in_item.samples[1]     = s_tdata[27:20];
		in_item.samples[2]     = s_tdata[35:28];
		in_item.samples[3]     = s_tdata[43:36];
		in_item.effect_length  = s_tdata[59:44];
		in_item.effect_repeat  = s_tdata[60];
		in_item.target_channel = s_tdata[62:61];
	end

	assign s_tready = (cnt_q != 2'd2);
	assign push     = s_tvalid && s_tready;
	assign q_valid  = (cnt_q != 2'd0);
	assign pop      = q_valid && q_ready;
	assign q_item   = buf_q[rd_ptr_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (push) buf_q[wr_ptr_q] <= in_item;
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

[rtl/psm_back.sv]
// psm_back: channel state, mix arithmetic and output register
// depends on psm_pkg
module psm_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [psm_pkg::VOL_W-1:0] cfg_wdata,
	input  logic                   q_valid,
	output logic                   q_ready,
	input  psm_pkg::item_t         q_item,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output psm_pkg::result_t       m_res
);
	import psm_pkg::*;

	logic [VOL_W-1:0]              eff_vol_q;
	logic [NUM_CH-1:0]             act_q, rep_q;
	logic [NUM_CH-1:0][POS_W-1:0]  len_q, pos_q;
	logic [NUM_CH-1:0][VOL_W-1:0]  vol_q;
	logic                          mus_q;

	logic [NUM_CH-1:0]             act_d, rep_d;
	logic [NUM_CH-1:0][POS_W-1:0]  len_d, pos_d;
	logic [NUM_CH-1:0][VOL_W-1:0]  vol_d;
	logic                          mus_d;
	logic                          ok_d;
	logic [CH_W-1:0]               take_d;
	logic [SAMP_W-1:0]             mix_d;
	logic                          fire;
	logic                          out_valid_q;
	result_t                       res_q;

	logic signed [9:0]  term [NUM_CH];
	logic signed [17:0] prod [NUM_CH];
	logic signed [11:0] sum;
	logic [POS_W:0]     nxt;
	logic               found;

	assign q_ready  = !out_valid_q || m_tready;
	assign fire     = q_valid && q_ready;
	assign m_tvalid = out_valid_q;
	assign m_res    = res_q;

	// per-channel scaled terms, truncated toward zero
	always_comb begin
		for (int c = 0; c < NUM_CH; c++) begin
			prod[c] = $signed({1'b0, q_item.samples[c]} - 9'sd128) * $signed({1'b0, vol_q[c]});
			if (prod[c][17] && prod[c][7:0] != 8'd0)
				term[c] = 10'(prod[c] >>> 8) + 10'sd1;
			else
				term[c] = 10'(prod[c] >>> 8);
			if (!act_q[c]) term[c] = '0;
		end
	end

	// next state and mix
	always_comb begin
		act_d  = act_q;
		rep_d  = rep_q;
		len_d  = len_q;
		pos_d  = pos_q;
		vol_d  = vol_q;
		mus_d  = mus_q;
		ok_d   = 1'b0;
		take_d = '0;
		mix_d  = SILENCE;
		found  = 1'b0;
		sum    = '0;
		nxt    = '0;
		case (q_item.action)
			ACT_TICK: begin
				if (mus_q && q_item.music_valid)
					sum = 12'($signed({1'b0, q_item.music_pcm}) - 10'sd128);
				for (int c = 0; c < NUM_CH; c++) begin
					sum = sum + 12'(term[c]);
					if (act_q[c]) begin
						nxt = {1'b0, pos_q[c]} + 1'b1;
						if (nxt >= {1'b0, len_q[c]}) begin
							if (rep_q[c]) nxt = '0;
							else act_d[c] = 1'b0;
						end
						pos_d[c] = nxt[POS_W-1:0];
					end
				end
				if (sum > 12'sd127)       mix_d = 8'd255;
				else if (sum < -12'sd128) mix_d = 8'd0;
				else                      mix_d = 8'(sum + 12'sd128);
			end
			ACT_START_FX: begin
				for (int c = 0; c < NUM_CH; c++) begin
					if (!act_q[c] && !found) begin
						found    = 1'b1;
						len_d[c] = q_item.effect_length;
						pos_d[c] = '0;
						rep_d[c] = q_item.effect_repeat;
						vol_d[c] = eff_vol_q;
						act_d[c] = 1'b1;
						ok_d     = 1'b1;
						take_d   = CH_W'(c);
					end
				end
			end
			ACT_STOP_FX:   act_d[q_item.target_channel] = 1'b0;
			ACT_START_MUS: mus_d = 1'b1;
			ACT_STOP_MUS:  mus_d = 1'b0;
			default: ;
		endcase
	end

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) eff_vol_q <= VOL_RESET;
		else if (cfg_we) eff_vol_q <= cfg_wdata;
	end

	// channel state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= '0;
			rep_q <= '0;
			len_q <= '0;
			pos_q <= '0;
			vol_q <= {NUM_CH{CH_VOL_RST}};
			mus_q <= 1'b0;
		end else if (fire) begin
			act_q <= act_d;
			rep_q <= rep_d;
			len_q <= len_d;
			pos_q <= pos_d;
			vol_q <= vol_d;
			mus_q <= mus_d;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (q_ready) out_valid_q <= q_valid;
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q.mixed_sample  <= mix_d;
			res_q.start_ok      <= ok_d;
			res_q.start_channel <= take_d;
			res_q.active_mask   <= act_d;
			res_q.music_on      <= mus_d;
			res_q.next_pos      <= pos_d;
		end
	end

endmodule
